// ===== hw/rtl/rvdec_pkg.sv =====
package rvdec_pkg;

	typedef logic [5:0] mnem_t;
	typedef logic [6:0] opcode_t;

	typedef enum logic [2:0] {
		FMT_UNKNOWN = 3'd0,
		FMT_R       = 3'd1,
		FMT_I       = 3'd2,
		FMT_S       = 3'd3,
		FMT_B       = 3'd4,
		FMT_U       = 3'd5,
		FMT_J       = 3'd6
	} fmt_t;

	typedef struct packed {
		fmt_t        fmt;
		mnem_t       id;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [31:0] imm;
	} dec_t;

	localparam opcode_t OPC_OP       = 7'b0110011;
	localparam opcode_t OPC_OP_32    = 7'b0111011;
	localparam opcode_t OPC_LOAD     = 7'b0000011;
	localparam opcode_t OPC_OP_IMM   = 7'b0010011;
	localparam opcode_t OPC_OP_IMM32 = 7'b0011011;
	localparam opcode_t OPC_JALR     = 7'b1100111;
	localparam opcode_t OPC_SYSTEM   = 7'b1110011;
	localparam opcode_t OPC_MISC_MEM = 7'b0001111;
	localparam opcode_t OPC_STORE    = 7'b0100011;
	localparam opcode_t OPC_BRANCH   = 7'b1100011;
	localparam opcode_t OPC_AUIPC    = 7'b0010111;
	localparam opcode_t OPC_LUI      = 7'b0110111;
	localparam opcode_t OPC_JAL      = 7'b1101111;

	localparam logic [6:0] F7_BASE   = 7'b0000000;
	localparam logic [6:0] F7_ALT    = 7'b0100000;
	localparam logic [6:0] F7_MULDIV = 7'b0000001;

	localparam logic [5:0] SHI_LOGIC = 6'b000000;
	localparam logic [5:0] SHI_ARITH = 6'b010000;

	localparam logic [11:0] IMM_ECALL  = 12'd0;
	localparam logic [11:0] IMM_EBREAK = 12'd1;

	localparam logic [2:0] F3_0 = 3'd0;
	localparam logic [2:0] F3_1 = 3'd1;
	localparam logic [2:0] F3_2 = 3'd2;
	localparam logic [2:0] F3_3 = 3'd3;
	localparam logic [2:0] F3_4 = 3'd4;
	localparam logic [2:0] F3_5 = 3'd5;
	localparam logic [2:0] F3_6 = 3'd6;
	localparam logic [2:0] F3_7 = 3'd7;

	localparam mnem_t MN_UNKNOWN = 6'd0;
	localparam mnem_t MN_MUL     = 6'd1;
	localparam mnem_t MN_ADD     = 6'd9;
	localparam mnem_t MN_SUB     = 6'd10;
	localparam mnem_t MN_SLL     = 6'd11;
	localparam mnem_t MN_SLT     = 6'd12;
	localparam mnem_t MN_SLTU    = 6'd13;
	localparam mnem_t MN_XOR     = 6'd14;
	localparam mnem_t MN_SRL     = 6'd15;
	localparam mnem_t MN_SRA     = 6'd16;
	localparam mnem_t MN_OR      = 6'd17;
	localparam mnem_t MN_AND     = 6'd18;
	localparam mnem_t MN_ADDW    = 6'd19;
	localparam mnem_t MN_SUBW    = 6'd20;
	localparam mnem_t MN_SLLW    = 6'd21;
	localparam mnem_t MN_SRLW    = 6'd22;
	localparam mnem_t MN_SRAW    = 6'd23;
	localparam mnem_t MN_LB      = 6'd24;
	localparam mnem_t MN_FENCE   = 6'd31;
	localparam mnem_t MN_ADDI    = 6'd33;
	localparam mnem_t MN_SLLI    = 6'd34;
	localparam mnem_t MN_SLTI    = 6'd35;
	localparam mnem_t MN_SLTIU   = 6'd36;
	localparam mnem_t MN_XORI    = 6'd37;
	localparam mnem_t MN_SRLI    = 6'd38;
	localparam mnem_t MN_SRAI    = 6'd39;
	localparam mnem_t MN_ORI     = 6'd40;
	localparam mnem_t MN_ANDI    = 6'd41;
	localparam mnem_t MN_ADDIW   = 6'd42;
	localparam mnem_t MN_SLLIW   = 6'd43;
	localparam mnem_t MN_SRLIW   = 6'd44;
	localparam mnem_t MN_SRAIW   = 6'd45;
	localparam mnem_t MN_JALR    = 6'd46;
	localparam mnem_t MN_ECALL   = 6'd47;
	localparam mnem_t MN_EBREAK  = 6'd48;
	localparam mnem_t MN_SB      = 6'd49;
	localparam mnem_t MN_BEQ     = 6'd53;
	localparam mnem_t MN_BNE     = 6'd54;
	localparam mnem_t MN_BLT     = 6'd55;
	localparam mnem_t MN_AUIPC   = 6'd59;
	localparam mnem_t MN_LUI     = 6'd60;
	localparam mnem_t MN_JAL     = 6'd61;

	function automatic mnem_t pick_alt(input logic [6:0] f7, input mnem_t base_id,
			input mnem_t alt_id);
		mnem_t r;
		if (f7 == F7_BASE) r = base_id;
		else if (f7 == F7_ALT) r = alt_id;
		else r = MN_UNKNOWN;
		return r;
	endfunction

	function automatic mnem_t pick_shift(input logic [5:0] hi6, input mnem_t base_id,
			input mnem_t alt_id);
		mnem_t r;
		if (hi6 == SHI_LOGIC) r = base_id;
		else if (hi6 == SHI_ARITH) r = alt_id;
		else r = MN_UNKNOWN;
		return r;
	endfunction

	function automatic dec_t decode(input logic [31:0] w);
		dec_t       d;
		opcode_t    opc;
		logic [2:0] f3;
		logic [6:0] f7;
		logic [5:0] hi6;
		logic [11:0] imm12;
		logic [31:0] imm_i;
		opc   = w[6:0];
		f3    = w[14:12];
		f7    = w[31:25];
		hi6   = w[31:26];
		imm12 = w[31:20];
		imm_i = {{20{w[31]}}, w[31:20]};
		d = '0;
		d.fmt = FMT_UNKNOWN;
		case (opc)
			OPC_OP, OPC_OP_32: begin
				d.fmt = FMT_R;
				d.rd  = w[11:7];
				d.rs1 = w[19:15];
				d.rs2 = w[24:20];
				if (opc == OPC_OP) begin
					if (f7 == F7_MULDIV) begin
						d.id = MN_MUL + {3'b000, f3};
					end else begin
						case (f3)
							F3_0: d.id = pick_alt(f7, MN_ADD, MN_SUB);
							F3_1: d.id = MN_SLL;
							F3_2: d.id = MN_SLT;
							F3_3: d.id = MN_SLTU;
							F3_4: d.id = MN_XOR;
							F3_5: d.id = pick_alt(f7, MN_SRL, MN_SRA);
							F3_6: d.id = MN_OR;
							default: d.id = MN_AND;
						endcase
					end
				end else begin
					case (f3)
						F3_0: d.id = pick_alt(f7, MN_ADDW, MN_SUBW);
						F3_1: d.id = MN_SLLW;
						F3_5: d.id = pick_alt(f7, MN_SRLW, MN_SRAW);
						default: d.id = MN_UNKNOWN;
					endcase
				end
			end
			OPC_LOAD, OPC_MISC_MEM, OPC_OP_IMM, OPC_OP_IMM32, OPC_JALR, OPC_SYSTEM: begin
				d.fmt = FMT_I;
				d.rd  = w[11:7];
				d.rs1 = w[19:15];
				d.imm = imm_i;
				case (opc)
					OPC_LOAD: begin
						d.id = (f3 != F3_7) ? MN_LB + {3'b000, f3} : MN_UNKNOWN;
					end
					OPC_MISC_MEM: begin
						d.id = (f3[2:1] == 2'b00) ? MN_FENCE + {3'b000, f3} : MN_UNKNOWN;
					end
					OPC_OP_IMM: begin
						case (f3)
							F3_0: d.id = MN_ADDI;
							F3_1: d.id = MN_SLLI;
							F3_2: d.id = MN_SLTI;
							F3_3: d.id = MN_SLTIU;
							F3_4: d.id = MN_XORI;
							F3_5: d.id = pick_shift(hi6, MN_SRLI, MN_SRAI);
							F3_6: d.id = MN_ORI;
							default: d.id = MN_ANDI;
						endcase
					end
					OPC_OP_IMM32: begin
						case (f3)
							F3_0: d.id = MN_ADDIW;
							F3_1: d.id = MN_SLLIW;
							F3_5: d.id = pick_shift(hi6, MN_SRLIW, MN_SRAIW);
							default: d.id = MN_UNKNOWN;
						endcase
					end
					OPC_JALR: d.id = MN_JALR;
					default: begin
						if (f3 == F3_0 && imm12 == IMM_ECALL) d.id = MN_ECALL;
						else if (f3 == F3_0 && imm12 == IMM_EBREAK) d.id = MN_EBREAK;
						else d.id = MN_UNKNOWN;
					end
				endcase
			end
			OPC_STORE: begin
				d.fmt = FMT_S;
				d.rs1 = w[19:15];
				d.rs2 = w[24:20];
				d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
				d.id  = (f3[2] == 1'b0) ? MN_SB + {3'b000, f3} : MN_UNKNOWN;
			end
			OPC_BRANCH: begin
				d.fmt = FMT_B;
				d.rs1 = w[19:15];
				d.rs2 = w[24:20];
				d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
				if (f3 == F3_0) d.id = MN_BEQ;
				else if (f3 == F3_1) d.id = MN_BNE;
				else if (f3[2]) d.id = MN_BLT + {4'b0000, f3[1:0]};
				else d.id = MN_UNKNOWN;
			end
			OPC_AUIPC, OPC_LUI: begin
				d.fmt = FMT_U;
				d.rd  = w[11:7];
				d.imm = {w[31:12], 12'h000};
				d.id  = (opc == OPC_AUIPC) ? MN_AUIPC : MN_LUI;
			end
			OPC_JAL: begin
				d.fmt = FMT_J;
				d.rd  = w[11:7];
				d.id  = MN_JAL;
				d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
			end
			default: begin
				d = '0;
				d.fmt = FMT_UNKNOWN;
			end
		endcase
		return d;
	endfunction

endpackage

// ===== hw/rtl/rv64im_instruction_decoder.sv =====
// RV64IM instruction decoder. One 32-bit instruction word is taken per beat and one
// decoded result is given per beat, at a sustained rate of one instruction every
// cycle while out_stall is low; a taken word goes first into the input register and
// then, after the opcode and funct table lookup, into the result register. Output
// stall holds the result register and backs up into the input register only when
// both are full, so a new word is still taken while a finished result waits.
// Unknown opcodes give all-zero fields; a known opcode with an unknown funct code in
// the bits it checks keeps its format and fields and gives mnemonic 0.
module rv64im_instruction_decoder
	import rvdec_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        instr,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         format_kind,
	output logic [5:0]         mnemonic_id,
	output logic [4:0]         dest_reg,
	output logic [4:0]         src_reg_one,
	output logic [4:0]         src_reg_two,
	output logic signed [31:0] immediate
);

	logic        valid_s1;
	logic [31:0] instr_s1;
	logic        valid_s2;
	dec_t        dec_s2;
	dec_t        dec_comb;
	logic        adv_s1;
	logic        adv_s2;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_comb begin
		dec_comb = decode(instr_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			instr_s1 <= instr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			dec_s2 <= dec_comb;
		end
	end

	assign out_valid   = valid_s2;
	assign format_kind = dec_s2.fmt;
	assign mnemonic_id = dec_s2.id;
	assign dest_reg    = dec_s2.rd;
	assign src_reg_one = dec_s2.rs1;
	assign src_reg_two = dec_s2.rs2;
	assign immediate   = $signed(dec_s2.imm);

	// A taken beat always lands in the input register.
	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted beat did not reach the input register");

	// A word held in the input register moves on whenever the result register frees up.
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> out_valid)
		else $error("decoded word was lost between stages");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && format_kind == FMT_UNKNOWN |->
			mnemonic_id == MN_UNKNOWN && immediate == 32'sd0 && dest_reg == 5'd0 &&
			src_reg_one == 5'd0 && src_reg_two == 5'd0)
		else $error("unknown opcode gave nonzero fields");

	a_r_no_imm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && format_kind == FMT_R |-> immediate == 32'sd0)
		else $error("R format result carries an immediate");

endmodule
